@@ src/ism_pkg.sv @@
// Shared types and constants of the interrupt status and mask unit.
package ism_pkg;

  localparam int WORD_W    = 24;
  localparam int SRC_W     = 48;
  localparam int ADDR_W    = 7;
  localparam int SRC_IDX_W = 6;
  localparam int GEN_DEPTH = 64;
  localparam int GEN_IDX_W = 6;
  localparam int GRP_W     = 8;
  localparam int GRP_N     = SRC_W / GRP_W;
  localparam int GRP_IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RAISE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [ADDR_W-1:0]    reg_address;
    logic [WORD_W-1:0]    write_data;
    logic [SRC_IDX_W-1:0] source_index;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]    read_data;
    logic                 addr_error;
    logic                 irq_out;
    logic                 pending_found;
    logic [SRC_IDX_W-1:0] first_pending;
    logic                 source_masked;
    logic                 source_status;
  } out_item_t;

  typedef struct packed {
    logic                 en;
    logic [GEN_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    data;
  } gen_wr_t;

endpackage

@@ src/ism_first_pend.sv @@
// Priority encoder that finds the lowest pending unmasked interrupt source.
module ism_first_pend (
  input  logic [ism_pkg::SRC_W-1:0]     pend,
  output logic                          found,
  output logic [ism_pkg::SRC_IDX_W-1:0] first
);
  import ism_pkg::*;

  logic [GRP_N-1:0]     grp_any;
  logic [GRP_IDX_W-1:0] grp_idx [GRP_N];

  // First level: eight sources per group, all groups side by side.
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |pend[g*GRP_W +: GRP_W];
      grp_idx[g] = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (pend[g*GRP_W + b]) begin
          grp_idx[g] = GRP_IDX_W'(b);
        end
      end
    end
  end

  // Second level: the lowest group with a pending source wins.
  always_comb begin
    found = 1'b0;
    first = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found = 1'b1;
        first = {(SRC_IDX_W - GRP_IDX_W)'(g), grp_idx[g]};
      end
    end
  end

endmodule

@@ src/ism_gen_file.sv @@
// General register file: a 64-entry memory with per-entry valid bits and write bypass.
module ism_gen_file (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ism_pkg::GEN_IDX_W-1:0] rd_idx,
  input  ism_pkg::gen_wr_t              wr,
  output logic [ism_pkg::WORD_W-1:0]    rd_data
);
  import ism_pkg::*;

  logic [WORD_W-1:0]    mem_r [GEN_DEPTH];
  logic [WORD_W-1:0]    rdata_r;
  logic [GEN_DEPTH-1:0] vld_r;
  logic                 vld_rd_r;
  logic                 hit_r;
  logic [WORD_W-1:0]    hdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.data;
    end
    rdata_r <= mem_r[rd_idx];
    hdata_r <= wr.data;
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.idx] <= 1'b1;
      end
      vld_rd_r <= vld_r[rd_idx];
      hit_r    <= wr.en && (wr.idx == rd_idx);
    end
  end

  // A write in the same cycle as the read takes precedence over the stale memory word.
  assign rd_data = hit_r ? hdata_r : (vld_rd_r ? rdata_r : '0);

endmodule

@@ src/interrupt_status_mask_unit.sv @@
// Top level of the interrupt status and mask unit.
//
// Usage: a command is transferred in when start is high and busy is low.
// busy never rises, so one command may be transferred on every clock cycle.
// A command is a register read, a register write or an event raised on one
// interrupt source. Every command produces exactly one result, shown on
// out_data for a single cycle while out_valid is high.
// A transferred command is held in the input register, processed in the
// following cycle, and its result is then registered, so out_valid is high
// in the cycle after that. Throughput is one command per cycle; the
// registered read of the general register memory is what sets the input
// register stage.
// The receiver cannot stall: each result must be taken in the cycle it is
// shown. Every result reflects the state after its own command took effect.
// Reset (rst_n low, synchronous) clears all status bits, masks every source,
// and makes every general register read as zero until written. No clearing
// pass is needed, so the unit accepts commands right after reset.
module interrupt_status_mask_unit #(
  parameter int NUM_SOURCES      = 48,
  parameter int MAX_REG          = 63,
  parameter int STATUS_LOW_ADDR  = 0,
  parameter int MASK_LOW_ADDR    = 1,
  parameter int STATUS_HIGH_ADDR = 3,
  parameter int MASK_HIGH_ADDR   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ism_pkg::in_item_t  in_data,
  output logic               out_valid,
  output ism_pkg::out_item_t out_data
);
  import ism_pkg::*;

  localparam logic [ADDR_W-1:0] SL_ADDR = ADDR_W'(STATUS_LOW_ADDR);
  localparam logic [ADDR_W-1:0] ML_ADDR = ADDR_W'(MASK_LOW_ADDR);
  localparam logic [ADDR_W-1:0] SH_ADDR = ADDR_W'(STATUS_HIGH_ADDR);
  localparam logic [ADDR_W-1:0] MH_ADDR = ADDR_W'(MASK_HIGH_ADDR);
  localparam logic [ADDR_W-1:0] MAX_ADDR = ADDR_W'(MAX_REG);
  localparam logic [SRC_IDX_W-1:0] SRC_LIMIT = SRC_IDX_W'(NUM_SOURCES);
  // Sources at or above NUM_SOURCES never become pending.
  localparam logic [SRC_W-1:0] SRC_VALID =
    SRC_W'(((SRC_W + 1)'(1) << NUM_SOURCES) - (SRC_W + 1)'(1));

  logic       accept;
  logic       s1_vld_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  out_data_nxt;

  logic [SRC_W-1:0] status_r;
  logic [SRC_W-1:0] status_nxt;
  logic [SRC_W-1:0] mask_r;
  logic [SRC_W-1:0] mask_nxt;
  logic [SRC_W-1:0] pend;
  logic [SRC_W-1:0] status_sh;
  logic [SRC_W-1:0] mask_sh;

  logic                 is_rw;
  logic                 addr_err;
  logic                 src_ok;
  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    gen_rd_data;
  gen_wr_t              gen_wr;
  logic                 pend_found;
  logic [SRC_IDX_W-1:0] pend_first;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
  end

  // The general register file is read while the command enters the input register.
  ism_gen_file u_gen_file (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (in_data.reg_address[GEN_IDX_W-1:0]),
    .wr      (gen_wr),
    .rd_data (gen_rd_data)
  );

  assign is_rw    = (s1_item_r.command == CMD_READ) || (s1_item_r.command == CMD_WRITE);
  assign addr_err = is_rw && (s1_item_r.reg_address > MAX_ADDR);
  assign src_ok   = s1_item_r.source_index < SRC_LIMIT;

  // Command decode. Aliased word addresses resolve in the order status low,
  // mask low, status high, mask high; anything else is a general register.
  always_comb begin
    status_nxt = status_r;
    mask_nxt   = mask_r;
    rd_word    = '0;
    gen_wr.en   = 1'b0;
    gen_wr.idx  = s1_item_r.reg_address[GEN_IDX_W-1:0];
    gen_wr.data = s1_item_r.write_data;
    if (s1_vld_r) begin
      if (is_rw && !addr_err) begin
        priority if (s1_item_r.reg_address == SL_ADDR) begin
          rd_word    = status_r[WORD_W-1:0];
          status_nxt = status_r & ~{{(SRC_W - WORD_W){1'b0}}, s1_item_r.write_data};
        end else if (s1_item_r.reg_address == ML_ADDR) begin
          rd_word  = mask_r[WORD_W-1:0];
          mask_nxt = {mask_r[SRC_W-1:WORD_W], s1_item_r.write_data};
        end else if (s1_item_r.reg_address == SH_ADDR) begin
          rd_word    = status_r[SRC_W-1:WORD_W];
          status_nxt = status_r & ~{s1_item_r.write_data, {WORD_W{1'b0}}};
        end else if (s1_item_r.reg_address == MH_ADDR) begin
          rd_word  = mask_r[SRC_W-1:WORD_W];
          mask_nxt = {s1_item_r.write_data, mask_r[WORD_W-1:0]};
        end else begin
          rd_word   = gen_rd_data;
          gen_wr.en = (s1_item_r.command == CMD_WRITE);
        end
        // Register state only changes on writes.
        if (s1_item_r.command == CMD_READ) begin
          status_nxt = status_r;
          mask_nxt   = mask_r;
        end else begin
          rd_word = '0;
        end
      end else if ((s1_item_r.command == CMD_RAISE) && src_ok) begin
        status_nxt = status_r | (SRC_W'(1) << s1_item_r.source_index);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      mask_r   <= '1;
    end else begin
      status_r <= status_nxt;
      mask_r   <= mask_nxt;
    end
  end

  assign pend      = status_nxt & ~mask_nxt & SRC_VALID;
  assign status_sh = status_nxt >> s1_item_r.source_index;
  assign mask_sh   = mask_nxt >> s1_item_r.source_index;

  ism_first_pend u_first_pend (
    .pend  (pend),
    .found (pend_found),
    .first (pend_first)
  );

  always_comb begin
    out_data_nxt.read_data     = rd_word;
    out_data_nxt.addr_error    = addr_err;
    out_data_nxt.irq_out       = |pend;
    out_data_nxt.pending_found = pend_found;
    out_data_nxt.first_pending = pend_first;
    out_data_nxt.source_masked = src_ok && mask_sh[0];
    out_data_nxt.source_status = src_ok && status_sh[0];
  end

  // Result register: every processed command is strobed out for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept, 2))
    else $error("result strobe without a transfer two cycles earlier");

  a_irq_matches_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.irq_out == out_data_r.pending_found))
    else $error("irq line disagrees with the pending search");

  a_first_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pending_found) |-> (out_data_r.first_pending < SRC_LIMIT))
    else $error("reported pending source beyond the source count");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.addr_error) |-> (out_data_r.read_data == '0))
    else $error("out-of-range access returned data");

  a_reset_masks_all: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> ((mask_r == '1) && (status_r == '0)))
    else $error("status or mask not at reset value after reset");
`endif

endmodule

@@ sim/ism_checker.sv @@
// Checker that predicts and compares every result of the interrupt status and mask unit.
`timescale 1ns / 1ps

module ism_checker #(
  parameter int NUM_SOURCES      = 48,
  parameter int MAX_REG          = 63,
  parameter int STATUS_LOW_ADDR  = 0,
  parameter int MASK_LOW_ADDR    = 1,
  parameter int STATUS_HIGH_ADDR = 3,
  parameter int MASK_HIGH_ADDR   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  ism_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  ism_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 outstanding,
  output int                 results_checked,
  output int                 irq_results,
  output int                 error_results
);
  import ism_pkg::*;

  localparam logic [SRC_W-1:0] LIVE_SOURCES =
    (NUM_SOURCES >= SRC_W) ? '1 : ((SRC_W'(1) << NUM_SOURCES) - SRC_W'(1));

  // Shadow copy of the unit's state.
  logic [SRC_W-1:0]  shadow_status;
  logic [SRC_W-1:0]  shadow_mask;
  logic [WORD_W-1:0] shadow_regs [GEN_DEPTH];

  out_item_t         awaited_results [$];
  out_item_t         oldest;

  initial begin
    fail_count      = 0;
    outstanding     = 0;
    results_checked = 0;
    irq_results     = 0;
    error_results   = 0;
  end

  // Applies one command to the shadow state and returns the result it must produce.
  function automatic out_item_t apply_command(in_item_t c);
    out_item_t            r;
    logic [SRC_W-1:0]     pend;
    logic                 src_ok;
    logic [WORD_W-1:0]    d;
    logic [GEN_IDX_W-1:0] gidx;
    int                   addr;
    r      = '0;
    d      = c.write_data;
    addr   = int'(c.reg_address);
    gidx   = c.reg_address[GEN_IDX_W-1:0];
    src_ok = (int'(c.source_index) < NUM_SOURCES) && (int'(c.source_index) < SRC_W);
    unique case (cmd_t'(c.command))
      CMD_READ, CMD_WRITE: begin
        if (addr > MAX_REG) begin
          r.addr_error = 1'b1;
        end else if (cmd_t'(c.command) == CMD_READ) begin
          // The first matching word wins when addresses alias.
          if (addr == STATUS_LOW_ADDR)       r.read_data = shadow_status[23:0];
          else if (addr == MASK_LOW_ADDR)    r.read_data = shadow_mask[23:0];
          else if (addr == STATUS_HIGH_ADDR) r.read_data = shadow_status[47:24];
          else if (addr == MASK_HIGH_ADDR)   r.read_data = shadow_mask[47:24];
          else                               r.read_data = shadow_regs[gidx];
        end else begin
          // Status words clear the bits written as one; mask words are replaced.
          if (addr == STATUS_LOW_ADDR)       shadow_status[23:0]  &= ~d;
          else if (addr == MASK_LOW_ADDR)    shadow_mask[23:0]    = d;
          else if (addr == STATUS_HIGH_ADDR) shadow_status[47:24] &= ~d;
          else if (addr == MASK_HIGH_ADDR)   shadow_mask[47:24]   = d;
          else                               shadow_regs[gidx] = d;
        end
      end
      CMD_RAISE: begin
        if (src_ok) shadow_status[c.source_index] = 1'b1;
      end
      default: ;
    endcase

    pend            = shadow_status & ~shadow_mask & LIVE_SOURCES;
    r.irq_out       = |pend;
    r.pending_found = |pend;
    for (int i = SRC_W - 1; i >= 0; i--) begin
      if (pend[i]) r.first_pending = SRC_IDX_W'(i);
    end
    if (src_ok) begin
      r.source_masked = shadow_mask[c.source_index];
      r.source_status = shadow_status[c.source_index];
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_status = '0;
      shadow_mask   = '1;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      awaited_results.delete();
    end else begin
      // Results are taken before new commands so that a stray result is caught.
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no command waiting for it");
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          results_checked++;
          check_field("read_data", oldest.read_data, out_data.read_data);
          check_field("addr_error", WORD_W'(oldest.addr_error),
                      WORD_W'(out_data.addr_error));
          check_field("irq_out", WORD_W'(oldest.irq_out), WORD_W'(out_data.irq_out));
          check_field("pending_found", WORD_W'(oldest.pending_found),
                      WORD_W'(out_data.pending_found));
          check_field("first_pending", WORD_W'(oldest.first_pending),
                      WORD_W'(out_data.first_pending));
          check_field("source_masked", WORD_W'(oldest.source_masked),
                      WORD_W'(out_data.source_masked));
          check_field("source_status", WORD_W'(oldest.source_status),
                      WORD_W'(out_data.source_status));
          if (oldest.pending_found) irq_results++;
          if (oldest.addr_error) error_results++;
        end
      end
      if (start && !busy) awaited_results.push_back(apply_command(in_data));
    end
    outstanding = awaited_results.size();
  end

endmodule

@@ sim/tb_interrupt_status_mask_unit.sv @@
// Testbench top for the interrupt status and mask unit: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_interrupt_status_mask_unit;
  import ism_pkg::*;

  localparam int NUM_SOURCES      = 48;
  localparam int MAX_REG          = 63;
  localparam int STATUS_LOW_ADDR  = 0;
  localparam int MASK_LOW_ADDR    = 1;
  localparam int STATUS_HIGH_ADDR = 3;
  localparam int MASK_HIGH_ADDR   = 4;
  localparam int WORD_ONES        = 24'hffffff;

  // Number of random commands, and how many at the end go out back to back.
  localparam int RANDOM_COMMANDS  = 1780;
  localparam int STEADY_TAIL      = 200;
  // Cycles without any transfer after which the run is declared hung.
  localparam int HANG_LIMIT       = 1000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int outstanding;
  int results_checked;
  int irq_results;
  int error_results;
  int sent_by_cmd [4];
  int idle_cycles;

  interrupt_status_mask_unit #(
    .NUM_SOURCES     (NUM_SOURCES),
    .MAX_REG         (MAX_REG),
    .STATUS_LOW_ADDR (STATUS_LOW_ADDR),
    .MASK_LOW_ADDR   (MASK_LOW_ADDR),
    .STATUS_HIGH_ADDR(STATUS_HIGH_ADDR),
    .MASK_HIGH_ADDR  (MASK_HIGH_ADDR)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // The checker sits beside the unit, predicts every result and counts mismatches.
  ism_checker #(
    .NUM_SOURCES     (NUM_SOURCES),
    .MAX_REG         (MAX_REG),
    .STATUS_LOW_ADDR (STATUS_LOW_ADDR),
    .MASK_LOW_ADDR   (MASK_LOW_ADDR),
    .STATUS_HIGH_ADDR(STATUS_HIGH_ADDR),
    .MASK_HIGH_ADDR  (MASK_HIGH_ADDR)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .irq_results    (irq_results),
    .error_results  (error_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles in which neither a command nor a result is
  // transferred. A correct unit answers every command and the longest
  // deliberate pause is far shorter than HANG_LIMIT, so the limit is generous.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_command(cmd_t op, int unsigned addr,
                                            int unsigned data, int unsigned src);
    in_item_t c;
    c.command      = op;
    c.reg_address  = ADDR_W'(addr);
    c.write_data   = WORD_W'(data);
    c.source_index = SRC_IDX_W'(src);
    return c;
  endfunction

  // Presents a command at the falling edge and holds it until the unit takes it.
  // A following command is loaded at the next falling edge without dropping
  // start in between, so back-to-back transfers see one assignment per step.
  task automatic issue(input in_item_t c);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_by_cmd[c.command]++;
  endtask

  // Leaves the input idle for the requested time; the payload carries junk meanwhile
  // so that the unit is seen to ignore it.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= make_command(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 127),
                              $urandom, $urandom_range(0, 63));
    end
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Register addresses lean on the four interrupt words, since those drive
  // the interesting behavior; general registers and bad addresses fill the rest.
  function automatic int unsigned pick_address();
    case ($urandom_range(0, 9))
      0, 1:    return STATUS_LOW_ADDR;
      2:       return STATUS_HIGH_ADDR;
      3:       return MASK_LOW_ADDR;
      4:       return MASK_HIGH_ADDR;
      5, 6, 7: return $urandom_range(0, MAX_REG);
      default: return $urandom_range(MAX_REG + 1, 127);
    endcase
  endfunction

  // Data for writes: sparse patterns keep a few sources unmasked or cleared
  // at a time, so that pending sources come and go instead of saturating.
  function automatic int unsigned pick_data();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return WORD_ONES;
      2, 3:    return $urandom & WORD_ONES;
      4:       return 1 << $urandom_range(0, WORD_W - 1);
      default: return $urandom & $urandom & $urandom & WORD_ONES;
    endcase
  endfunction

  function automatic in_item_t random_command();
    int unsigned src;
    int unsigned pick;
    src  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                        : $urandom_range(0, NUM_SOURCES - 1);
    pick = $urandom_range(0, 19);
    if (pick < 8) return make_command(CMD_RAISE, $urandom_range(0, 127), $urandom, src);
    if (pick < 13) return make_command(CMD_WRITE, pick_address(), pick_data(), src);
    if (pick < 18) return make_command(CMD_READ, pick_address(), $urandom, src);
    return make_command(CMD_NOP, $urandom_range(0, 127), $urandom, src);
  endfunction

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. After reset every source is masked and nothing is pending.
    issue(make_command(CMD_READ,  MASK_LOW_ADDR,    0, 0));
    issue(make_command(CMD_READ,  MASK_HIGH_ADDR,   0, 47));
    issue(make_command(CMD_READ,  STATUS_LOW_ADDR,  0, 0));
    issue(make_command(CMD_READ,  MAX_REG,          0, 0));
    // A general register holds a full word and reads it back.
    issue(make_command(CMD_WRITE, 5,         WORD_ONES, 63));
    issue(make_command(CMD_READ,  5,                 0, 5));
    issue(make_command(CMD_WRITE, 2,          24'h5a5a5a, 2));
    issue(make_command(CMD_READ,  2,                 0, 2));
    issue(make_command(CMD_WRITE, MAX_REG,    24'h123456, 1));
    issue(make_command(CMD_READ,  MAX_REG,           0, 1));
    // A masked source is recorded but raises no interrupt until unmasked.
    issue(make_command(CMD_RAISE, 0,                 0, 0));
    issue(make_command(CMD_WRITE, MASK_LOW_ADDR,     0, 0));
    issue(make_command(CMD_RAISE, 0,                 0, 23));
    issue(make_command(CMD_RAISE, 0,                 0, 0));
    issue(make_command(CMD_RAISE, 127,       WORD_ONES, 47));
    issue(make_command(CMD_WRITE, MASK_HIGH_ADDR,    0, 47));
    // Clearing status bits moves the lowest pending source upward.
    issue(make_command(CMD_WRITE, STATUS_LOW_ADDR,   1, 0));
    issue(make_command(CMD_WRITE, STATUS_LOW_ADDR, WORD_ONES, 23));
    issue(make_command(CMD_READ,  STATUS_HIGH_ADDR,  0, 47));
    // Sources past the last one raise nothing and read as zero.
    issue(make_command(CMD_RAISE, 0,                 0, NUM_SOURCES));
    issue(make_command(CMD_RAISE, 0,                 0, 63));
    // Addresses past the top of the map are flagged and change nothing.
    issue(make_command(CMD_READ,  127,               0, 47));
    issue(make_command(CMD_WRITE, MAX_REG + 1, 24'habcdef, 47));
    // The unused command does nothing, whatever its payload.
    issue(make_command(CMD_NOP,   127,       WORD_ONES, 47));
    issue(make_command(CMD_WRITE, STATUS_HIGH_ADDR, WORD_ONES, 47));
    issue(make_command(CMD_WRITE, MASK_LOW_ADDR,  WORD_ONES, 0));
    drain();

    // Random part: idle bursts in two of every three runs of 150 commands, a
    // full drain halfway, and a tail sent back to back.
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n == RANDOM_COMMANDS / 2) drain();
      if (n < RANDOM_COMMANDS - STEADY_TAIL && (n / 150) % 3 != 2 &&
          $urandom_range(0, 4) == 0) begin
        hold_off($urandom_range(1, 7));
      end
      issue(random_command());
    end

    drain();
    repeat (4) @(posedge clk);

    $display("Covered %0d reads, %0d writes, %0d raised events and %0d unused commands.",
             sent_by_cmd[CMD_READ], sent_by_cmd[CMD_WRITE], sent_by_cmd[CMD_RAISE],
             sent_by_cmd[CMD_NOP]);
    $display("Checked %0d results: %0d with a pending source, %0d with a bad address.",
             results_checked, irq_results, error_results);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
